// ===== hdl/tdcpf_pkg.sv =====
// Package: payload structs, register map and arithmetic helpers of the dot-crawl filter.
package tdcpf_pkg;

	localparam int SampleBits = 16;
	localparam int AddrBits = 5;

	localparam logic [2:0] RegLuma2d = 3'd0;
	localparam logic [2:0] RegLumaT = 3'd1;
	localparam logic [2:0] RegChromaT1 = 3'd2;
	localparam logic [2:0] RegChromaT2 = 3'd3;
	localparam logic [2:0] RegDepth = 3'd4;

	localparam logic [8:0] Luma2dReset = 9'd20;
	localparam logic [7:0] LumaTReset = 8'd20;
	localparam logic [7:0] ChromaT1Reset = 8'd15;
	localparam logic [7:0] ChromaT2Reset = 8'd5;
	localparam logic [4:0] DepthReset = 5'd8;

	localparam logic [8:0] Luma2dOff = 9'd510;
	localparam logic [7:0] ChromaT2Off = 8'd255;
	localparam logic [4:0] DepthMin = 5'd8;

	localparam logic CmdLuma = 1'b0;
	localparam logic CmdChroma = 1'b1;

	typedef struct packed {
		logic                  cmd;
		logic                  on_border;
		logic [SampleBits-1:0] center;
		logic [SampleBits-1:0] left_px;
		logic [SampleBits-1:0] right_px;
		logic [SampleBits-1:0] two_rows_above;
		logic [SampleBits-1:0] two_rows_below;
		logic [SampleBits-1:0] frame_back_two;
		logic [SampleBits-1:0] frame_back_one;
		logic [SampleBits-1:0] frame_ahead_one;
		logic [SampleBits-1:0] frame_ahead_two;
	} nbhd_t;

	typedef struct packed {
		logic [SampleBits-1:0] pixel_out;
		logic                  altered;
	} result_t;

	// ((1 << depth) - 1) / 255 for depths 8 to 16
	function automatic logic [8:0] scale_factor(input logic [4:0] depth);
		logic [8:0] k;
		case (depth)
			5'd8: k = 9'd1;
			5'd9: k = 9'd2;
			5'd10: k = 9'd4;
			5'd11: k = 9'd8;
			5'd12: k = 9'd16;
			5'd13: k = 9'd32;
			5'd14: k = 9'd64;
			5'd15: k = 9'd128;
			5'd16: k = 9'd257;
			default: k = 9'd1;
		endcase
		return k;
	endfunction

	function automatic logic [15:0] absdiff16(input logic [15:0] a, input logic [15:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic [16:0] absdiff17(input logic [16:0] a, input logic [16:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

endpackage

// ===== hdl/temporal_dot_crawl_pixel_filter.sv =====
// Top level: dot-crawl pixel filter with input register, filter logic and result register.
//
//   channel   handshake                        payload
//   nbhd      nbhd_valid / nbhd_ready          tdcpf_pkg::nbhd_t (one pixel neighborhood)
//   result    result_valid / result_ready      tdcpf_pkg::result_t (filtered pixel, altered)
//   config    psel penable pwrite pready       paddr, pwdata, prdata (five registers)
//
// One item per cycle while the result side does not stall; each item passes the input register
// and leaves from the result register.
// The filter is combinational: one pass of compares, one 9 x 9 and three 8 x 9 threshold scalings.
// arst_n clears both valid flags and loads the register reset values.
// A stalled result holds the input register; the input side stalls only when both are full.
module temporal_dot_crawl_pixel_filter #(
	parameter int MAX_SAMPLE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            nbhd_valid,
	output logic                            nbhd_ready,
	input  tdcpf_pkg::nbhd_t                nbhd,
	output logic                            result_valid,
	input  logic                            result_ready,
	output tdcpf_pkg::result_t              result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tdcpf_pkg::AddrBits-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import tdcpf_pkg::*;

	localparam logic [4:0] DepthMax = 5'(MAX_SAMPLE_BITS);

	logic [8:0] luma_2d_q;
	logic [7:0] luma_t_q;
	logic [7:0] chroma_t1_q;
	logic [7:0] chroma_t2_q;
	logic [4:0] depth_q;

	logic [2:0] reg_idx;
	logic       cfg_write;

	assign pready = 1'b1;
	assign reg_idx = paddr[AddrBits-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_2d_q <= Luma2dReset;
			luma_t_q <= LumaTReset;
			chroma_t1_q <= ChromaT1Reset;
			chroma_t2_q <= ChromaT2Reset;
			depth_q <= DepthReset;
		end else if (cfg_write) begin
			case (reg_idx)
				RegLuma2d: luma_2d_q <= pwdata[8:0];
				RegLumaT: luma_t_q <= pwdata[7:0];
				RegChromaT1: chroma_t1_q <= pwdata[7:0];
				RegChromaT2: chroma_t2_q <= pwdata[7:0];
				RegDepth: depth_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			RegLuma2d: prdata = {23'd0, luma_2d_q};
			RegLumaT: prdata = {24'd0, luma_t_q};
			RegChromaT1: prdata = {24'd0, chroma_t1_q};
			RegChromaT2: prdata = {24'd0, chroma_t2_q};
			RegDepth: prdata = {27'd0, depth_q};
			default: prdata = 32'd0;
		endcase
	end

	// handshake and pipeline registers
	logic    valid_s1;
	nbhd_t   nbhd_s1;
	logic    advance;
	result_t result_next;

	assign advance = !result_valid || result_ready;
	assign nbhd_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (nbhd_ready) begin
				valid_s1 <= nbhd_valid;
			end
			if (advance) begin
				result_valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (nbhd_valid && nbhd_ready) begin
			nbhd_s1 <= nbhd;
		end
		if (advance && valid_s1) begin
			result <= result_next;
		end
	end

	// filter
	logic [4:0]  depth_c;
	logic [8:0]  k;
	logic [17:0] t2d;
	logic [16:0] tt;
	logic [16:0] t1;
	logic [16:0] t2;
	logic [16:0] cc;
	logic [16:0] sum_lr;
	logic [16:0] sum_ud;
	logic [15:0] d_pn;
	logic [15:0] d_cpp;
	logic [15:0] d_cnn;
	logic [15:0] d_cp;
	logic [15:0] d_cn;
	logic [16:0] avg_sum;
	logic        spatial_hit;
	logic        luma_stable;
	logic        chroma_stable;
	logic        chroma_outlier;
	logic        luma_on;
	logic        chroma_on;

	always_comb begin
		if (depth_q < DepthMin) begin
			depth_c = DepthMin;
		end else if (depth_q > DepthMax) begin
			depth_c = DepthMax;
		end else begin
			depth_c = depth_q;
		end
		k = scale_factor(depth_c);
		t2d = luma_2d_q * k;
		tt = 17'(luma_t_q * k);
		t1 = 17'(chroma_t1_q * k);
		t2 = 17'(chroma_t2_q * k);

		cc = {nbhd_s1.center, 1'b0};
		sum_lr = {1'b0, nbhd_s1.left_px} + {1'b0, nbhd_s1.right_px};
		sum_ud = {1'b0, nbhd_s1.two_rows_above} + {1'b0, nbhd_s1.two_rows_below};
		d_pn = absdiff16(nbhd_s1.frame_back_one, nbhd_s1.frame_ahead_one);
		d_cpp = absdiff16(nbhd_s1.center, nbhd_s1.frame_back_two);
		d_cnn = absdiff16(nbhd_s1.center, nbhd_s1.frame_ahead_two);
		d_cp = absdiff16(nbhd_s1.center, nbhd_s1.frame_back_one);
		d_cn = absdiff16(nbhd_s1.center, nbhd_s1.frame_ahead_one);

		spatial_hit = ({1'b0, absdiff17(sum_lr, cc)} > t2d)
			|| ({1'b0, absdiff17(sum_ud, cc)} > t2d);
		luma_stable = ({1'b0, d_pn} <= tt) && ({1'b0, d_cpp} <= tt)
			&& ({1'b0, d_cnn} <= tt);
		chroma_stable = ({1'b0, d_pn} <= t1) && ({1'b0, d_cpp} <= t1)
			&& ({1'b0, d_cnn} <= t1);
		chroma_outlier = ({1'b0, d_cp} > t2) && ({1'b0, d_cn} > t2);

		luma_on = (nbhd_s1.cmd == CmdLuma) && (luma_2d_q < Luma2dOff)
			&& (luma_t_q != 8'd0) && !nbhd_s1.on_border;
		chroma_on = (nbhd_s1.cmd == CmdChroma) && (chroma_t2_q != ChromaT2Off);

		// round up toward the closer temporal neighbor, next frame wins ties
		if (d_cn <= d_cp) begin
			avg_sum = {1'b0, nbhd_s1.frame_ahead_one} + {1'b0, nbhd_s1.center} + 17'd1;
		end else begin
			avg_sum = {1'b0, nbhd_s1.frame_back_one} + {1'b0, nbhd_s1.center} + 17'd1;
		end

		result_next.altered = (luma_on && spatial_hit && luma_stable)
			|| (chroma_on && chroma_stable && chroma_outlier);
		result_next.pixel_out = result_next.altered ? avg_sum[16:1] : nbhd_s1.center;
	end

endmodule

// ===== hdl/tdcpf_checker.sv =====
// Checker: port-level assertions for the dot-crawl filter, bound to the top level.
module tdcpf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            nbhd_valid,
	input logic                            nbhd_ready,
	input logic                            result_valid,
	input logic                            result_ready,
	input tdcpf_pkg::result_t              result
);
	import tdcpf_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	a_rise_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(nbhd_valid && nbhd_ready, 2))
		else $error("result appeared without an item accepted two cycles earlier");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		nbhd_valid && nbhd_ready && result_valid && !result_ready
		|=> nbhd_ready == result_ready)
		else $error("input ready does not follow result ready with both stages full");

endmodule

bind temporal_dot_crawl_pixel_filter tdcpf_checker u_tdcpf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.nbhd_valid(nbhd_valid),
	.nbhd_ready(nbhd_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result(result)
);

// ===== test/tb_temporal_dot_crawl_pixel_filter.sv =====
// Testbench: self-checking stimulus and predictor for the temporal dot-crawl pixel filter.
`timescale 1ns / 1ps

module tb_temporal_dot_crawl_pixel_filter;
	import tdcpf_pkg::*;

	localparam int ClkPeriod = 10;
	localparam int MaxSampleBits = 16;
	localparam int CycleLimit = 400000;
	localparam int PhaseItems = 200;
	localparam logic [2:0] RegUnusedLow = 3'd5;
	localparam logic [2:0] RegUnusedHigh = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	logic nbhd_valid;
	logic nbhd_ready;
	nbhd_t nbhd;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic psel;
	logic penable;
	logic pwrite;
	logic [AddrBits-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	logic [8:0] luma_edge_limit = Luma2dReset;
	logic [7:0] luma_still_limit = LumaTReset;
	logic [7:0] chroma_still_limit = ChromaT1Reset;
	logic [7:0] chroma_spike_limit = ChromaT2Reset;
	logic [4:0] sample_bits = DepthReset;

	result_t expected_pixels[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int stall_left = 0;
	bit send_gaps_on = 1'b1;
	bit result_stalls_on = 1'b1;

	temporal_dot_crawl_pixel_filter #(
		.MAX_SAMPLE_BITS(MaxSampleBits)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.nbhd_valid(nbhd_valid),
		.nbhd_ready(nbhd_ready),
		.nbhd(nbhd),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #(ClkPeriod / 2) clk = ~clk;

	function automatic int depth_scale(logic [4:0] bits_cfg);
		int d;
		d = int'(bits_cfg);
		if (d < 8)
			d = 8;
		if (d > MaxSampleBits)
			d = MaxSampleBits;
		return ((1 << d) - 1) / 255;
	endfunction

	function automatic int gap(int a, int b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic int closer_average(int c, int p, int n);
		if (gap(n, c) <= gap(p, c))
			return (n + c + 1) >> 1;
		return (p + c + 1) >> 1;
	endfunction

	function automatic result_t filter_pixel(nbhd_t px);
		int k;
		int c;
		int p;
		int n;
		int pp;
		int nn;
		int twice_c;
		int lim_a;
		int lim_b;
		result_t res;
		k = depth_scale(sample_bits);
		c = int'(px.center);
		p = int'(px.frame_back_one);
		n = int'(px.frame_ahead_one);
		pp = int'(px.frame_back_two);
		nn = int'(px.frame_ahead_two);
		twice_c = 2 * c;
		res.pixel_out = px.center;
		res.altered = 1'b0;
		if (px.cmd == CmdChroma) begin
			if (chroma_spike_limit != ChromaT2Off) begin
				lim_a = int'(chroma_still_limit) * k;
				lim_b = int'(chroma_spike_limit) * k;
				if (gap(p, n) <= lim_a && gap(c, pp) <= lim_a && gap(c, nn) <= lim_a &&
						gap(c, p) > lim_b && gap(c, n) > lim_b) begin
					res.pixel_out = 16'(closer_average(c, p, n));
					res.altered = 1'b1;
				end
			end
		end else if (luma_edge_limit < Luma2dOff && luma_still_limit != 0 && !px.on_border) begin
			lim_a = int'(luma_edge_limit) * k;
			lim_b = int'(luma_still_limit) * k;
			if ((gap(int'(px.left_px) + int'(px.right_px), twice_c) > lim_a ||
					gap(int'(px.two_rows_above) + int'(px.two_rows_below), twice_c) > lim_a) &&
					gap(p, n) <= lim_b && gap(c, pp) <= lim_b && gap(c, nn) <= lim_b) begin
				res.pixel_out = 16'(closer_average(c, p, n));
				res.altered = 1'b1;
			end
		end
		return res;
	endfunction

	function automatic logic [15:0] near(int mid, int spread, int top);
		int v;
		v = mid + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > top)
			v = top;
		return 16'(v);
	endfunction

	function automatic nbhd_t make_item(logic cmd, logic border, logic [15:0] c, logic [15:0] l,
			logic [15:0] r, logic [15:0] up, logic [15:0] dn, logic [15:0] pp, logic [15:0] p,
			logic [15:0] n, logic [15:0] nn);
		return '{cmd, border, c, l, r, up, dn, pp, p, n, nn};
	endfunction

	function automatic nbhd_t make_neighborhood(logic is_chroma);
		logic [159:0] noise;
		nbhd_t px;
		int k;
		int top;
		int base;
		int lim;
		int sp_t;
		int sp_s;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
		px = noise[$bits(nbhd_t)-1:0];
		px.cmd = is_chroma ? CmdChroma : CmdLuma;
		if ($urandom_range(0, 4) == 0)
			return px;
		px.on_border = ($urandom_range(0, 7) == 0);
		k = depth_scale(sample_bits);
		if (sample_bits < DepthMin)
			top = 255;
		else if (sample_bits >= 16 || $urandom_range(0, 15) == 0)
			top = 65535;
		else
			top = (1 << sample_bits) - 1;
		if (is_chroma) begin
			lim = (chroma_still_limit > chroma_spike_limit) ? chroma_still_limit : chroma_spike_limit;
			sp_t = int'($urandom_range(0, 2 * lim * k + 4));
		end else begin
			sp_t = int'($urandom_range(0, 2 * int'(luma_still_limit) * k + 4));
		end
		sp_s = int'($urandom_range(0, 2 * int'(luma_edge_limit) * k + 4));
		base = int'($urandom_range(0, top));
		px.center = 16'(base);
		px.frame_back_one = near(base, sp_t, top);
		px.frame_ahead_one = near(base, sp_t, top);
		px.frame_back_two = near(base, sp_t / 2, top);
		px.frame_ahead_two = near(base, sp_t / 2, top);
		px.left_px = near(base, sp_s, top);
		px.right_px = near(base, sp_s, top);
		px.two_rows_above = near(base, sp_s, top);
		px.two_rows_below = near(base, sp_s, top);
		return px;
	endfunction

	task automatic send_pixel(nbhd_t px);
		if (send_gaps_on && $urandom_range(0, 3) == 0) begin
			nbhd_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		nbhd <= px;
		nbhd_valid <= 1'b1;
		do @(posedge clk); while (!nbhd_ready);
		expected_pixels.push_back(filter_pixel(px));
	endtask

	task automatic wait_idle();
		nbhd_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			RegLuma2d: luma_edge_limit = value[8:0];
			RegLumaT: luma_still_limit = value[7:0];
			RegChromaT1: chroma_still_limit = value[7:0];
			RegChromaT2: chroma_spike_limit = value[7:0];
			RegDepth: sample_bits = value[4:0];
			default: ;
		endcase
	endtask

	task automatic test_reset_values();
		send_pixel(make_item(CmdLuma, 0, 100, 100, 100, 100, 100, 100, 100, 100, 100));
		send_pixel(make_item(CmdLuma, 0, 100, 150, 150, 100, 100, 100, 90, 110, 100));
		send_pixel(make_item(CmdLuma, 1, 100, 150, 150, 100, 100, 100, 90, 110, 100));
		send_pixel(make_item(CmdLuma, 0, 100, 100, 100, 40, 40, 100, 104, 97, 100));
		send_pixel(make_item(CmdLuma, 0, 100, 150, 150, 100, 100, 100, 50, 150, 100));
		send_pixel(make_item(CmdLuma, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_pixel(make_item(CmdLuma, 1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
		send_pixel(make_item(CmdLuma, 0, '1, 0, 0, 0, 0, 0, 0, 0, 0));
		send_pixel(make_item(CmdLuma, 0, 0, '1, '1, '1, '1, '1, '1, '1, '1));
		send_pixel(make_item(CmdChroma, 0, 100, 0, 0, 0, 0, 100, 110, 112, 100));
		send_pixel(make_item(CmdChroma, 1, 100, '1, 3, 77, '1, 100, 110, 112, 100));
		send_pixel(make_item(CmdChroma, 0, 100, 0, 0, 0, 0, 100, 90, 110, 100));
	endtask

	task automatic test_disabled_planes();
		wait_idle();
		write_reg(RegLuma2d, 32'(Luma2dOff));
		send_pixel(make_item(CmdLuma, 0, 100, 150, 150, 100, 100, 100, 90, 110, 100));
		wait_idle();
		write_reg(RegLuma2d, 32'd511);
		send_pixel(make_item(CmdLuma, 0, 100, 150, 150, 100, 100, 100, 90, 110, 100));
		wait_idle();
		write_reg(RegLuma2d, 32'(Luma2dReset));
		write_reg(RegLumaT, 32'd0);
		send_pixel(make_item(CmdLuma, 0, 100, 150, 150, 100, 100, 100, 90, 110, 100));
		wait_idle();
		write_reg(RegChromaT2, 32'(ChromaT2Off));
		send_pixel(make_item(CmdChroma, 0, 100, 0, 0, 0, 0, 100, 110, 112, 100));
		send_pixel(make_item(CmdLuma, 0, 100, 150, 150, 100, 100, 100, 90, 110, 100));
		wait_idle();
		write_reg(RegLumaT, 32'(LumaTReset));
		write_reg(RegChromaT2, 32'(ChromaT2Reset));
	endtask

	task automatic test_depth_range();
		wait_idle();
		write_reg(RegDepth, 32'd3);
		send_pixel(make_item(CmdLuma, 0, 100, 150, 150, 100, 100, 100, 90, 110, 100));
		wait_idle();
		write_reg(RegDepth, 32'd20);
		send_pixel(make_item(CmdLuma, 0, 30000, 40000, 40000, 30000, 30000, 30000, 27000, 33000,
			30000));
		send_pixel(make_item(CmdChroma, 0, 30000, 0, 0, 0, 0, 30000, 32000, 32500, 30000));
		wait_idle();
		write_reg(RegDepth, 32'd16);
		send_pixel(make_item(CmdLuma, 0, 30000, 40000, 40000, 30000, 30000, 30000, 27000, 33000,
			30000));
		wait_idle();
		write_reg(RegDepth, 32'(DepthReset));
		send_pixel(make_item(CmdLuma, 0, 16'hF000, 16'hF100, 16'hF100, 16'hF000, 16'hF000,
			16'hF000, 16'hEFF0, 16'hF008, 16'hF000));
	endtask

	task automatic test_unknown_register();
		wait_idle();
		write_reg(RegUnusedLow, 32'd0);
		write_reg(RegUnusedHigh, '1);
		send_pixel(make_item(CmdLuma, 0, 100, 150, 150, 100, 100, 100, 90, 110, 100));
		send_pixel(make_item(CmdChroma, 0, 100, 0, 0, 0, 0, 100, 110, 112, 100));
	endtask

	task automatic test_random_phases();
		logic [8:0] edge_lim;
		logic [7:0] still_lim;
		logic [7:0] t1;
		logic [7:0] t2;
		logic [4:0] depth_val;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					edge_lim = Luma2dReset;
					still_lim = LumaTReset;
					t1 = ChromaT1Reset;
					t2 = ChromaT2Reset;
					depth_val = DepthReset;
				end
				1: begin
					edge_lim = 9'd0;
					still_lim = 8'd1;
					t1 = 8'd0;
					t2 = 8'd0;
					depth_val = DepthMin;
				end
				2: begin
					edge_lim = 9'(Luma2dOff - 9'd1);
					still_lim = 8'd255;
					t1 = 8'd255;
					t2 = 8'(ChromaT2Off - 8'd1);
					depth_val = 5'd16;
				end
				default: begin
					edge_lim = 9'($urandom_range(0, 511));
					still_lim = 8'($urandom_range(0, 255));
					t1 = 8'($urandom_range(0, 255));
					t2 = 8'($urandom_range(0, 255));
					depth_val = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) :
						5'($urandom_range(8, 16));
				end
			endcase
			wait_idle();
			write_reg(RegLuma2d, 32'(edge_lim));
			write_reg(RegLumaT, 32'(still_lim));
			write_reg(RegChromaT1, 32'(t1));
			write_reg(RegChromaT2, 32'(t2));
			write_reg(RegDepth, 32'(depth_val));
			if (phase == 7) begin
				send_gaps_on = 1'b0;
				result_stalls_on = 1'b0;
			end
			for (int i = 0; i < PhaseItems; i++) begin
				if (phase == 3 && i == PhaseItems / 2)
					wait_idle();
				send_pixel(make_neighborhood(1'($urandom_range(0, 1))));
			end
		end
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (result_stalls_on && $urandom_range(0, 5) == 0) begin
			result_ready <= 1'b0;
			stall_left <= $urandom_range(0, 18);
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_pixels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: pixel_out %h altered %b", result.pixel_out,
						result.altered);
			end else begin
				want = expected_pixels.pop_front();
				if (result.pixel_out !== want.pixel_out || result.altered !== want.altered) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: pixel_out exp %h got %h, altered exp %b got %b",
							want.pixel_out, result.pixel_out, want.altered, result.altered);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		nbhd_valid <= 1'b0;
		nbhd <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_disabled_planes();
		test_depth_range();
		test_unknown_register();
		test_random_phases();
		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/tdcpf_pkg.sv
hdl/temporal_dot_crawl_pixel_filter.sv
hdl/tdcpf_checker.sv
test/tb_temporal_dot_crawl_pixel_filter.sv
